// ===== hdl/cursor_line_edit_buffer_unit_macros.svh =====
// Assertion macros shared by the line-edit buffer modules.
`ifndef CURSOR_LINE_EDIT_BUFFER_UNIT_MACROS_SVH
`define CURSOR_LINE_EDIT_BUFFER_UNIT_MACROS_SVH

`ifndef SYNTH
`define CLEBU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("clebu assertion failed");
`define CLEBU_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("clebu reset assertion failed");
`else
`define CLEBU_ASSERT(lbl, prop)
`define CLEBU_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== hdl/clebu_pkg.sv =====
package clebu_pkg;

  localparam int DEPTH_DEF = 64;

  typedef enum logic [2:0] {
    FUNC_LEFT  = 3'd0,
    FUNC_RIGHT = 3'd1,
    FUNC_BKSP  = 3'd2,
    FUNC_INS   = 3'd3,
    FUNC_DUMP  = 3'd4
  } func_t;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] ch;
  } in_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic [6:0] text_length;
    logic [6:0] cursor_at;
    logic       status;
    logic       last_of_run;
  } out_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  typedef struct packed {
    logic edit;
    logic dump_step;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic cnt_zero;
    logic dump_last;
  } stat_t;

endpackage

// ===== hdl/clebu_ctrl.sv =====
`include "cursor_line_edit_buffer_unit_macros.svh"

module clebu_ctrl
  import clebu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  in_t   in_data,
  output logic  in_stall,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_free;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign out_free = !stat.out_busy || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cmd.edit      = 1'b0;
    cmd.dump_step = 1'b0;
    in_stall      = 1'b1;
    accept        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = !out_free;
        accept   = in_valid && out_free;
        if (accept) begin
          if (in_data.func == FUNC_DUMP && !stat.cnt_zero) begin
            state_nxt = ST_DUMP;
          end else begin
            cmd.edit = 1'b1;
          end
        end
      end
      ST_DUMP: begin
        if (out_free) begin
          cmd.dump_step = 1'b1;
          if (stat.dump_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `CLEBU_ASSERT(a_dump_blocks_input, state_r == ST_DUMP |-> in_stall)
  `CLEBU_ASSERT_RST(a_reset_idle, !rst_n |=> state_r == ST_IDLE)
  `CLEBU_ASSERT(a_one_cmd, !(cmd.edit && cmd.dump_step))

endmodule

// ===== hdl/clebu_dp.sv =====
`include "cursor_line_edit_buffer_unit_macros.svh"

module clebu_dp
  import clebu_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)
(
  input  logic  clk,
  input  logic  rst_n,
  input  in_t   in_data,
  input  cmd_t  cmd,
  input  logic  out_stall,
  output stat_t stat,
  output logic  out_valid,
  output out_t  out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [7:0]    cell_r   [DEPTH];
  logic [7:0]    cell_nxt [DEPTH];
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;
  logic [CW-1:0] dump_idx_r;
  logic          out_valid_r;
  out_t          out_data_r;
  logic          st;
  logic          shift_up, shift_dn;
  logic          dump_last;

  always_comb begin
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    st         = 1'b0;
    shift_up   = 1'b0;
    shift_dn   = 1'b0;
    case (in_data.func)
      FUNC_LEFT: begin
        if (cursor_r == '0) st = 1'b1;
        else cursor_nxt = cursor_r - 1'b1;
      end
      FUNC_RIGHT: begin
        if (cursor_r >= count_r) st = 1'b1;
        else cursor_nxt = cursor_r + 1'b1;
      end
      FUNC_BKSP: begin
        if (cursor_r == '0) begin
          st = 1'b1;
        end else begin
          shift_dn   = cmd.edit;
          count_nxt  = count_r - 1'b1;
          cursor_nxt = cursor_r - 1'b1;
        end
      end
      FUNC_INS: begin
        if (count_r >= FULL) begin
          st = 1'b1;
        end else begin
          shift_up   = cmd.edit;
          count_nxt  = count_r + 1'b1;
          cursor_nxt = cursor_r + 1'b1;
        end
      end
      default: begin
        st = 1'b1;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IDX  = CW'(i);
    localparam logic [CW-1:0] IDX1 = CW'(i + 1);
    logic [7:0] below, above;
    if (i == 0) begin : g_first
      assign below = cell_r[i];
    end else begin : g_mid_lo
      assign below = cell_r[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign above = cell_r[i];
    end else begin : g_mid_hi
      assign above = cell_r[i+1];
    end
    assign cell_nxt[i] =
      shift_up ? ((IDX > cursor_r) ? below :
                  (IDX == cursor_r) ? in_data.ch : cell_r[i]) :
      shift_dn ? ((IDX1 >= cursor_r && IDX1 < count_r) ? above : cell_r[i]) :
      cmd.dump_step ? ((IDX1 < count_r) ? above :
                       (IDX1 == count_r) ? cell_r[0] : cell_r[i]) :
      cell_r[i];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  assign dump_last = (dump_idx_r + 1'b1) == count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cursor_r    <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.edit) begin
        count_r     <= count_nxt;
        cursor_r    <= cursor_nxt;
        out_valid_r <= 1'b1;
      end else if (cmd.dump_step) begin
        dump_idx_r  <= dump_last ? '0 : dump_idx_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edit) begin
      out_data_r.text_byte   <= 8'h00;
      out_data_r.text_length <= 7'(count_nxt);
      out_data_r.cursor_at   <= 7'(cursor_nxt);
      out_data_r.status      <= st;
      out_data_r.last_of_run <= 1'b1;
    end else if (cmd.dump_step) begin
      out_data_r.text_byte   <= cell_r[0];
      out_data_r.text_length <= 7'(count_r);
      out_data_r.cursor_at   <= 7'(cursor_r);
      out_data_r.status      <= 1'b0;
      out_data_r.last_of_run <= dump_last;
    end
  end

  assign stat.out_busy  = out_valid_r;
  assign stat.cnt_zero  = (count_r == '0);
  assign stat.dump_last = dump_last;
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;

  `CLEBU_ASSERT(a_cursor_in_text, cursor_r <= count_r)
  `CLEBU_ASSERT(a_count_bound, count_r <= FULL)
  `CLEBU_ASSERT(a_dump_nonempty, cmd.dump_step |-> count_r != '0)

endmodule

// ===== hdl/cursor_line_edit_buffer_unit.sv =====
// Channel  Direction  Handshake        Payload
// in_      input      valid / stall    in_t  {func, ch}
// out_     output     valid / stall    out_t {text_byte, text_length, cursor_at,
//                                             status, last_of_run}
// Left, right, backspace and insert each give one result: the character cells
// shift as a chain, all in parallel. Dump of a non-empty line gives one result per stored
// character (a rotate of the cell chain), and no command is taken while it runs.
// Reset clears count, cursor and control; cell contents are not reset.
// A stalled output holds its result; input stalls until the output register frees.
module cursor_line_edit_buffer_unit
  import clebu_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  cmd_t  cmd;
  stat_t stat;

  clebu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  clebu_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import clebu_pkg::*;

  localparam int LINE_MAX = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int LONG_HOLD = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_CMDS = 390;

  // func codes outside the defined command set; the block leaves the line as it is and sets status
  localparam logic [2:0] FUNC_RSVD5 = 3'd5;
  localparam logic [2:0] FUNC_RSVD7 = 3'd7;

  localparam int MODE_GROW = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_EDIT = 2;

  typedef struct packed {
    in_t  cmd;
    logic drain_first;
    logic hold_rx;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  stim_t cmd_q[$];
  out_t  line_result_q[$];

  logic [7:0] shadow_text[LINE_MAX];
  int shadow_len = 0;
  int shadow_cur = 0;

  int errors = 0;
  int cyc = 0;
  bit quiet = 1'b0;
  bit sent_ok = 1'b0;
  int tx_wait = 0;
  int rx_wait = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int n_cmds = 0;
  int n_results = 0;
  int n_dump_bytes = 0;
  int n_full_drops = 0;

  cursor_line_edit_buffer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic logic [2:0] pick_func(int mode);
    int r;
    int ins_lim, left_lim, right_lim, bksp_lim, dump_lim;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW: begin
        ins_lim = 55; left_lim = 65; right_lim = 75; bksp_lim = 85; dump_lim = 95;
      end
      MODE_SHRINK: begin
        ins_lim = 20; left_lim = 30; right_lim = 40; bksp_lim = 80; dump_lim = 92;
      end
      default: begin
        ins_lim = 30; left_lim = 55; right_lim = 75; bksp_lim = 88; dump_lim = 96;
      end
    endcase
    if (r < ins_lim) return FUNC_INS;
    if (r < left_lim) return FUNC_LEFT;
    if (r < right_lim) return FUNC_RIGHT;
    if (r < bksp_lim) return FUNC_BKSP;
    if (r < dump_lim) return FUNC_DUMP;
    return 3'($urandom_range(FUNC_RSVD5, FUNC_RSVD7));
  endfunction

  task automatic push_cmd(logic [2:0] func, logic [7:0] ch, bit drain = 1'b0,
                          bit hold = 1'b0);
    stim_t s;
    s.cmd.func = func;
    s.cmd.ch = ch;
    s.drain_first = drain;
    s.hold_rx = hold;
    cmd_q.push_back(s);
  endtask

  // edit the shadow line and queue the results the command must produce
  task automatic apply_command(in_t cmd);
    out_t r;
    bit ignored;
    int i;
    r = '0;
    ignored = 1'b0;
    case (cmd.func)
      FUNC_LEFT: begin
        if (shadow_cur == 0) ignored = 1'b1;
        else shadow_cur--;
      end
      FUNC_RIGHT: begin
        if (shadow_cur >= shadow_len) ignored = 1'b1;
        else shadow_cur++;
      end
      FUNC_BKSP: begin
        if (shadow_cur == 0) begin
          ignored = 1'b1;
        end else begin
          for (i = shadow_cur - 1; i < shadow_len - 1; i++) shadow_text[i] = shadow_text[i + 1];
          shadow_len--;
          shadow_cur--;
        end
      end
      FUNC_INS: begin
        if (shadow_len >= LINE_MAX) begin
          ignored = 1'b1;
          n_full_drops++;
        end else begin
          for (i = shadow_len; i > shadow_cur; i--) shadow_text[i] = shadow_text[i - 1];
          shadow_text[shadow_cur] = cmd.ch;
          shadow_len++;
          shadow_cur++;
        end
      end
      FUNC_DUMP: begin
        if (shadow_len == 0) ignored = 1'b1;
      end
      default: ignored = 1'b1;
    endcase
    r.text_length = 7'(shadow_len);
    r.cursor_at = 7'(shadow_cur);
    if (cmd.func == FUNC_DUMP && shadow_len != 0) begin
      for (i = 0; i < shadow_len; i++) begin
        r.text_byte = shadow_text[i];
        r.status = 1'b0;
        r.last_of_run = (i == shadow_len - 1);
        line_result_q.push_back(r);
        n_dump_bytes++;
      end
    end else begin
      r.status = ignored;
      r.last_of_run = 1'b1;
      line_result_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 256 == 0) quiet <= ($urandom_range(0, 3) == 0);
  end

  // transfer monitor: predict on accepted commands, check accepted results
  always @(posedge clk) begin : monitor
    out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        apply_command(in_data);
        sent_ok = 1'b1;
        n_cmds++;
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (line_result_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          errors++;
        end else begin
          want = line_result_q.pop_front();
          if (out_data.text_byte !== want.text_byte) begin
            $display("%0t: text_byte exp %0h got %0h", $time, want.text_byte,
                     out_data.text_byte);
            errors++;
          end
          if (out_data.text_length !== want.text_length) begin
            $display("%0t: text_length exp %0d got %0d", $time, want.text_length,
                     out_data.text_length);
            errors++;
          end
          if (out_data.cursor_at !== want.cursor_at) begin
            $display("%0t: cursor_at exp %0d got %0d", $time, want.cursor_at,
                     out_data.cursor_at);
            errors++;
          end
          if (out_data.status !== want.status) begin
            $display("%0t: status exp %0b got %0b", $time, want.status, out_data.status);
            errors++;
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run exp %0b got %0b", $time, want.last_of_run,
                     out_data.last_of_run);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin : driver
    stim_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || sent_ok) begin
      sent_ok = 1'b0;
      if (tx_wait > 0) begin
        tx_wait <= tx_wait - 1;
        in_valid <= 1'b0;
      end else if (cmd_q.size() == 0 ||
                   (cmd_q[0].drain_first && line_result_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        nxt = cmd_q.pop_front();
        in_data <= nxt.cmd;
        in_valid <= 1'b1;
        if (nxt.hold_rx) hold_req <= hold_req + 1;
        tx_wait <= pick_gap();
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      rx_wait <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      rx_wait <= pick_gap();
    end
  end

  initial begin : stimulus
    int n;
    int mode;
    int seg;
    int i;
    logic [2:0] f;

    // directed: boundaries, empty dump, reserved codes, byte extremes
    push_cmd(FUNC_DUMP, 8'h00);
    push_cmd(FUNC_LEFT, 8'hFF);
    push_cmd(FUNC_BKSP, 8'h00);
    push_cmd(FUNC_RIGHT, 8'h00);
    for (f = FUNC_RSVD5; f <= FUNC_RSVD7 && f >= FUNC_RSVD5; f++) push_cmd(f, 8'hFF);
    push_cmd(FUNC_INS, 8'h00);
    push_cmd(FUNC_INS, 8'hFF);
    push_cmd(FUNC_LEFT, 8'h00);
    push_cmd(FUNC_INS, 8'hA5);
    push_cmd(FUNC_RIGHT, 8'h00);
    push_cmd(FUNC_RIGHT, 8'h00);
    push_cmd(FUNC_LEFT, 8'h00);
    push_cmd(FUNC_LEFT, 8'h00);
    push_cmd(FUNC_BKSP, 8'h00);
    push_cmd(FUNC_DUMP, 8'h00);
    push_cmd(FUNC_INS, 8'h5A);
    push_cmd(FUNC_DUMP, 8'h00);

    // fill to capacity, overflow, then dump the full line under a long hold
    for (i = 0; i < LINE_MAX + 3; i++)
      push_cmd(FUNC_INS, 8'($urandom_range(0, 255)), i == 0, i == LINE_MAX - 8);
    push_cmd(FUNC_RIGHT, 8'h00);
    push_cmd(FUNC_DUMP, 8'h00, 1'b0, 1'b1);

    n = 0;
    while (n < RANDOM_CMDS) begin
      mode = $urandom_range(MODE_GROW, MODE_EDIT);
      seg = $urandom_range(15, 45);
      for (i = 0; i < seg; i++) begin
        push_cmd(pick_func(mode), 8'($urandom_range(0, 255)),
                 i == 0 && $urandom_range(0, 4) == 0);
        n++;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (cmd_q.size() != 0 || in_valid || line_result_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d commands, checked %0d results (%0d from dumps)", n_cmds, n_results,
             n_dump_bytes);
    $display("%0d inserts dropped on a full line; boundaries, reserved codes covered",
             n_full_drops);
    if (errors == 0 && line_result_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    wait (cyc >= CYCLE_LIMIT);
    $display("%0t: timeout with %0d results outstanding", $time, line_result_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
